FILE: sv/csfw_pkg.sv
// Package for the counting semaphore with FIFO wait queue.
// Holds field widths, request and status codes, and shared struct types.
// No dependencies; compile first.
package csfw_pkg;

    localparam int FUNC_W   = 2;
    localparam int TID_W    = 8;
    localparam int PERMIT_W = 16;
    localparam int STATUS_W = 2;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_THREAD_BITS = 8;

    localparam logic [PERMIT_W-1:0] PERMIT_MAX = '1;

    localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_WAKE  = 1'b1;

    // Shared adder output: result plus carry (fits on subtract, overflow on add)
    typedef struct packed {
        logic [PERMIT_W-1:0] result;
        logic                flag;
    } alu_out_t;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    thread;
    } result_t;

endpackage

FILE: sv/csfw_if.sv
// Handshake interfaces for request, result and configuration channels.
// Depends on csfw_pkg for field widths.
interface csfw_req_if import csfw_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TID_W-1:0]    thread_id;
    logic [PERMIT_W-1:0] count;

    modport source (output valid, func, thread_id, count, input ready);
    modport sink   (input valid, func, thread_id, count, output ready);
endinterface

interface csfw_res_if import csfw_pkg::*;;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    woken_thread;
    logic                last;

    modport source (output valid, kind, status, woken_thread, last, input ready);
    modport sink   (input valid, kind, status, woken_thread, last, output ready);
endinterface

interface csfw_cfg_if import csfw_pkg::*;;
    logic                valid;
    logic                ready;
    logic [PERMIT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: sv/csfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/csfw_alu.sv
// Shared permit adder: saturating add, or subtract with fit flag; on add the flag means overflow.
// Depends on csfw_pkg.
module csfw_alu import csfw_pkg::*; (
    input  logic                sub,
    input  logic [PERMIT_W-1:0] a,
    input  logic [PERMIT_W-1:0] b,
    output alu_out_t            y
);

    logic [PERMIT_W:0] sum;

    // One adder: a + ~b + 1 on subtract, carry out means b <= a
    assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{PERMIT_W{1'b0}}, sub};

    always_comb
    begin
        y.flag = sum[PERMIT_W];
        if (sub || !sum[PERMIT_W])
        begin
            y.result = sum[PERMIT_W-1:0];
        end
        else
        begin
            y.result = PERMIT_MAX;
        end
    end

endmodule

FILE: sv/counting_semaphore_fifo_waiters_top.sv
// Top level of the counting semaphore with FIFO wait queue.
// Depends on csfw_pkg, csfw_if, csfw_ram and csfw_alu.
//
//   channel | dir | payload                              | transfer when
//   --------+-----+--------------------------------------+-------------------
//   req     | in  | func, thread_id, count               | req.valid & ready
//   res     | out | kind, status, woken_thread, last     | res.valid & ready
//   cfg     | in  | data (initial_permits)               | cfg.valid & ready
//
// A wait, a zero-count signal, any request on a closed semaphore, or an
// unused kind goes from S_EXEC straight to S_FLUSH. Other signals and
// closes step through S_READ and S_CHECK per released waiter, and a signal
// stops at a head waiter that does not fit: each wake reads the queue head
// from the RAM, and a signal checks it in the shared adder, so the RAM
// read paces the drain.
// Reset leaves permits at zero, the queue empty and the semaphore open.
// A stalled result output holds the sequencer; the final result waits in the
// output register while the next request is taken.
module counting_semaphore_fifo_waiters_top import csfw_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int THREAD_BITS = DEF_THREAD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    csfw_req_if.sink   req,
    csfw_res_if.source res,
    csfw_cfg_if.sink   cfg
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    // Thread ids are stored only as wide as both the parameter and the port allow
    localparam int ID_W    = (THREAD_BITS < TID_W) ? THREAD_BITS : TID_W;
    localparam int ENTRY_W = ID_W + PERMIT_W;

    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    // Sequencer state and latched request
    logic [2:0]          state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [ID_W-1:0]     tid_reg, tid_next;
    logic [PERMIT_W-1:0] cnt_reg, cnt_next;
    logic                close_mode_reg, close_mode_next;

    // Semaphore state
    logic [PERMIT_W-1:0] permits_reg, permits_next;
    logic                closed_reg, closed_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    // Pending result: held until we know whether another one follows
    result_t             pend_reg, pend_next;

    // Output register
    logic                res_valid_reg;
    result_t             res_data_reg;
    logic                res_last_reg;

    logic                cfg_fire, req_fire, slot_free;
    logic                push, push_last;
    logic                ram_wr, ram_rd;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [ID_W-1:0]     head_id;
    logic [PERMIT_W-1:0] head_cnt;
    logic                alu_sub;
    logic [PERMIT_W-1:0] alu_b;
    alu_out_t            alu_y;
    logic                cnt_zero;

    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req_fire  = req.valid && req.ready;
    assign slot_free = !res_valid_reg || res.ready;

    assign head_id  = ram_rd_data[ENTRY_W-1:PERMIT_W];
    assign head_cnt = ram_rd_data[PERMIT_W-1:0];
    assign cnt_zero = (cnt_reg == '0);

    // Waiter queue: id and count packed in one entry
    csfw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (tail_reg),
        .wr_data ({tid_reg, cnt_reg}),
        .rd_en   (ram_rd),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // Subtract for a wait take or a head-waiter check, add for a signal
    assign alu_sub = (state_reg == S_CHECK) || (func_reg == FUNC_WAIT);
    assign alu_b   = (state_reg == S_CHECK) ? head_cnt : cnt_reg;

    csfw_alu u_alu (
        .sub (alu_sub),
        .a   (permits_reg),
        .b   (alu_b),
        .y   (alu_y)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        tid_next        = tid_reg;
        cnt_next        = cnt_reg;
        close_mode_next = close_mode_reg;
        permits_next    = permits_reg;
        closed_next     = closed_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        ram_wr          = 1'b0;
        ram_rd          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    // Reload the counter and drop the queue and closed flag
                    permits_next = cfg.data;
                    closed_next  = 1'b0;
                    head_next    = '0;
                    tail_next    = '0;
                    fill_next    = '0;
                end
                else if (req_fire)
                begin
                    func_next  = req.func;
                    tid_next   = req.thread_id[ID_W-1:0];
                    cnt_next   = req.count;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pend_next.kind   = KIND_REPLY;
                pend_next.status = ST_OK;
                pend_next.thread = TID_W'(tid_reg);
                state_next       = S_FLUSH;
                case (func_reg)
                    FUNC_WAIT:
                    begin
                        if (closed_reg)
                        begin
                            pend_next.status = ST_CLOSED;
                        end
                        else if (cnt_zero)
                        begin
                            pend_next.status = ST_OK;
                        end
                        else if (alu_y.flag)
                        begin
                            permits_next = alu_y.result;
                        end
                        else if (fill_reg == FULL_FILL)
                        begin
                            pend_next.status = ST_FULL;
                        end
                        else
                        begin
                            // Enqueue the thread at the tail
                            ram_wr           = 1'b1;
                            tail_next        = next_ptr(tail_reg);
                            fill_next        = fill_reg + FILL_W'(1);
                            pend_next.status = ST_BLOCKED;
                        end
                    end
                    FUNC_SIGNAL:
                    begin
                        if (closed_reg)
                        begin
                            pend_next.status = ST_CLOSED;
                        end
                        else if (!cnt_zero)
                        begin
                            permits_next    = alu_y.result;
                            close_mode_next = 1'b0;
                            state_next      = S_READ;
                        end
                    end
                    FUNC_CLOSE:
                    begin
                        if (!closed_reg)
                        begin
                            closed_next     = 1'b1;
                            close_mode_next = 1'b1;
                            state_next      = S_READ;
                        end
                    end
                    default:
                    begin
                        pend_next.status = ST_OK;
                    end
                endcase
            end

            S_READ:
            begin
                // Fetch the head waiter, or finish when the queue is empty
                if (fill_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    ram_rd     = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (close_mode_reg || alu_y.flag)
                begin
                    // Another result follows, so release the pending one as not last
                    if (slot_free)
                    begin
                        push             = 1'b1;
                        pend_next.kind   = KIND_WAKE;
                        pend_next.status = close_mode_reg ? ST_CLOSED : ST_OK;
                        pend_next.thread = TID_W'(head_id);
                        if (!close_mode_reg)
                        begin
                            permits_next = alu_y.result;
                        end
                        head_next  = next_ptr(head_reg);
                        fill_next  = fill_reg - FILL_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            permits_reg   <= '0;
            closed_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            permits_reg <= permits_next;
            closed_reg  <= closed_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        tid_reg        <= tid_next;
        cnt_reg        <= cnt_next;
        close_mode_reg <= close_mode_next;
        pend_reg       <= pend_next;
        if (push)
        begin
            res_data_reg <= pend_reg;
            res_last_reg <= push_last;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.kind         = res_data_reg.kind;
    assign res.status       = res_data_reg.status;
    assign res.woken_thread = res_data_reg.thread;
    assign res.last         = res_last_reg;

endmodule

FILE: sv/csfw_chk.sv
// Port-level checker for the semaphore top level, attached by bind.
// Depends on csfw_pkg and counting_semaphore_fifo_waiters_top.
module csfw_chk import csfw_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic                res_kind,
    input logic [STATUS_W-1:0] res_status,
    input logic [TID_W-1:0]    res_woken_thread,
    input logic                res_last
);

    logic res_fire;

    assign res_fire = res_valid && res_ready;

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({res_kind, res_status, res_woken_thread, res_last}))
        else $error("result changed while stalled");

    // Not ready in the cycle after a request transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(req_valid && req_ready))
        else $error("config and request transfer in one cycle");

    a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && res_kind == KIND_WAKE |-> res_status == ST_OK || res_status == ST_CLOSED)
        else $error("wake with bad status");

    // A blocked or refused wait releases nobody
    a_refuse_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && res_kind == KIND_REPLY &&
            (res_status == ST_BLOCKED || res_status == ST_FULL) |-> res_last)
        else $error("blocked reply not last");

endmodule

bind counting_semaphore_fifo_waiters_top csfw_chk u_csfw_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .cfg_valid        (cfg.valid),
    .cfg_ready        (cfg.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_kind         (res.kind),
    .res_status       (res.status),
    .res_woken_thread (res.woken_thread),
    .res_last         (res.last)
);
